FILE: hw/rtl/led_breathing_color_scaler_unit_macros.svh
// ---------------------------------------------------------------------------
// LED breathing colour scaler - assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef LED_BREATHING_COLOR_SCALER_UNIT_MACROS_SVH
`define LED_BREATHING_COLOR_SCALER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LBCS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lbcs assertion failed");

// next-cycle implication
`define LBCS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lbcs assertion failed");

`else

`define LBCS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LBCS_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: hw/rtl/lbcs_pkg.sv
// ---------------------------------------------------------------------------
// lbcs_pkg
// Shared types, constants and the brightness table function.
// ---------------------------------------------------------------------------
`default_nettype none

package lbcs_pkg;

  localparam int ELAPSED_W  = 16;
  localparam int PERIOD_W   = 16;
  localparam int COLOR_W    = 8;
  localparam int SCALE_W    = 8;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 3 * COLOR_W;
  localparam int NUM_CH     = 3;
  localparam int CH_W       = 2;

  localparam int PHASE_TABLE_BITS_DEF = 8;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1500;

  localparam logic [CH_W-1:0] CH_RED   = 2'd0;
  localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF   = 2'd0,
    MODE_SOLID = 2'd1,
    MODE_PULSE = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 3'd0,
    CFG_RED    = 3'd1,
    CFG_GREEN  = 3'd2,
    CFG_BLUE   = 3'd3,
    CFG_PERIOD = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOOK,
    ST_MUL,
    ST_HOLD
  } ctrl_state_t;

  typedef struct packed {
    logic            start;
    logic            div_step;
    logic            cap_e;
    logic            look;
    logic            mul_en;
    logic [CH_W-1:0] mul_ch;
    logic            load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

  localparam longint unsigned Q30_ONE       = 64'd1073741824;
  localparam longint unsigned Q30_HALF_PI   = 64'd1686629713;
  localparam longint unsigned Q30_FLOOR_015 = 64'd161061274;

  // Q0.8 scale for a folded quarter-wave index j; elaboration-time only
  function automatic logic [SCALE_W-1:0] scale_q8_f(input int unsigned j,
                                                    input int unsigned bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned v;
    longint unsigned q;
    x    = (Q30_HALF_PI * longint'(j)) >> (bits - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    // Taylor series, odd terms to x^15
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
    term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
    term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
    if (sum > Q30_ONE) begin
      sum = Q30_ONE;
    end
    v = Q30_FLOOR_015 + (sum * 64'd85) / 64'd100;
    q = (v * 64'd256 + (64'd1 << 29)) >> 30;
    if (q > 64'd255) begin
      q = 64'd255;
    end
    return q[SCALE_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lbcs_ctrl.sv
// ---------------------------------------------------------------------------
// lbcs_ctrl
// Sequencer: request intake, divider steps, table read, per-channel
// multiply and hand-off to the output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "led_breathing_color_scaler_unit_macros.svh"

module lbcs_ctrl #(
  parameter int PHASE_TABLE_BITS = lbcs_pkg::PHASE_TABLE_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire lbcs_pkg::dp_sts_t sts,
  output lbcs_pkg::dp_cmd_t    cmd
);
  import lbcs_pkg::*;

  localparam int DIV_STEPS = ELAPSED_W + PHASE_TABLE_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int DIV_LAST  = DIV_STEPS - 1;
  localparam int CHAN_LAST = NUM_CH - 1;

  ctrl_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.start = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        // remainder holds elapsed mod period once the integer bits are through
        cmd.cap_e    = (cnt_r == CNT_W'(ELAPSED_W));
        if (cnt_r == CNT_W'(DIV_LAST)) begin
          cnt_nxt   = '0;
          state_nxt = ST_LOOK;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_ch = cnt_r[CH_W-1:0];
        if (cnt_r == CNT_W'(CHAN_LAST)) begin
          cnt_nxt   = '0;
          state_nxt = ST_HOLD;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_HOLD: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `LBCS_ASSERT_IMP(a_load_free, clk, rst_n, cmd.load_out, !sts.out_busy)
  `LBCS_ASSERT_IMP(a_mul_ch_range, clk, rst_n, state_r == ST_MUL,
                   cnt_r < CNT_W'(NUM_CH))
  `LBCS_ASSERT_NXT(a_start_div, clk, rst_n, cmd.start,
                   state_r == ST_DIV && cnt_r == '0)

endmodule

`default_nettype wire

FILE: hw/rtl/lbcs_dp.sv
// ---------------------------------------------------------------------------
// lbcs_dp
// Datapath: elapsed counter, restoring divider for phase, brightness table,
// shared 8x8 multiplier and output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "led_breathing_color_scaler_unit_macros.svh"

module lbcs_dp #(
  parameter int PHASE_TABLE_BITS = lbcs_pkg::PHASE_TABLE_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_restart,
  input  wire lbcs_pkg::dp_cmd_t               cmd,
  output lbcs_pkg::dp_sts_t                    sts,
  input  wire [lbcs_pkg::MODE_W-1:0]           mode,
  input  wire [lbcs_pkg::COLOR_W-1:0]          base_red,
  input  wire [lbcs_pkg::COLOR_W-1:0]          base_green,
  input  wire [lbcs_pkg::COLOR_W-1:0]          base_blue,
  input  wire [lbcs_pkg::PERIOD_W-1:0]         period,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [lbcs_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import lbcs_pkg::*;

  localparam int B       = PHASE_TABLE_BITS;
  localparam int DVD_W   = ELAPSED_W + B;
  localparam int HALF    = 1 << (B - 1);
  localparam int QUARTER = 1 << (B - 2);
  localparam int TIDX_W  = B - 1;

  logic [ELAPSED_W-1:0]  elapsed_r;
  logic [ELAPSED_W-1:0]  rem_r;
  logic [DVD_W-1:0]      dvd_r;
  logic [SCALE_W-1:0]    scale_r;
  logic [COLOR_W-1:0]    res_r [NUM_CH];
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_valid_r;

  // divider step
  logic [PERIOD_W:0]    rem_sh;
  logic                 q_bit;
  logic [ELAPSED_W-1:0] rem_step;
  logic [PERIOD_W:0]    e_inc;
  logic [ELAPSED_W-1:0] elapsed_nxt;
  logic [ELAPSED_W-1:0] e_start;

  assign rem_sh   = {rem_r, dvd_r[DVD_W-1]};
  assign q_bit    = (rem_sh >= {1'b0, period});
  assign rem_step = q_bit ? ELAPSED_W'(rem_sh - {1'b0, period}) : rem_sh[ELAPSED_W-1:0];
  assign e_inc    = {1'b0, rem_r} + (PERIOD_W + 1)'(1);
  assign elapsed_nxt = (e_inc == {1'b0, period}) ? '0 : e_inc[ELAPSED_W-1:0];
  assign e_start  = in_restart ? ELAPSED_W'(0) : elapsed_r;

  // quarter-wave table, folded index
  logic [SCALE_W-1:0] scale_tbl [QUARTER + 1];
  logic [B-1:0]       j_raw;
  logic [B-1:0]       j_fold;

  for (genvar g = 0; g <= QUARTER; g++) begin : g_tbl
    assign scale_tbl[g] = scale_q8_f(g, B);
  end

  assign j_raw  = {1'b0, dvd_r[B-2:0]};
  assign j_fold = (j_raw > B'(QUARTER)) ? (B'(HALF) - j_raw) : j_raw;

  // shared multiplier
  logic [COLOR_W-1:0]         mul_a;
  logic [COLOR_W+SCALE_W-1:0] prod;
  logic [COLOR_W-1:0]         res_val;

  always_comb begin
    unique case (cmd.mul_ch)
      CH_RED:   mul_a = base_red;
      CH_GREEN: mul_a = base_green;
      default:  mul_a = base_blue;
    endcase
  end

  assign prod = mul_a * scale_r;

  always_comb begin
    unique case (mode)
      MODE_SOLID: res_val = mul_a;
      MODE_PULSE: res_val = prod[COLOR_W+SCALE_W-1:SCALE_W];
      default:    res_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
    end else if (cmd.cap_e) begin
      elapsed_r <= elapsed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem_r <= '0;
      dvd_r <= {e_start, B'(0)};
    end else if (cmd.div_step) begin
      rem_r <= rem_step;
      dvd_r <= {dvd_r[DVD_W-2:0], q_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      scale_r <= scale_tbl[j_fold[TIDX_W-1:0]];
    end
    if (cmd.mul_en) begin
      res_r[cmd.mul_ch] <= res_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {res_r[CH_BLUE], res_r[CH_GREEN], res_r[CH_RED]};
    end
  end

  assign sts.out_busy = out_valid_r && !out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

  `LBCS_ASSERT_NXT(a_elapsed_wrap, clk, rst_n, cmd.cap_e, elapsed_r < period)
  `LBCS_ASSERT_NXT(a_start_rem, clk, rst_n, cmd.start, rem_r == '0)
  `LBCS_ASSERT_NXT(a_load_valid, clk, rst_n, cmd.load_out, out_valid_r)

endmodule

`default_nettype wire

FILE: hw/rtl/led_breathing_color_scaler_unit.sv
// ---------------------------------------------------------------------------
// led_breathing_color_scaler_unit
// One RGB drive value per millisecond tick: off, solid or breathing pulse.
// ---------------------------------------------------------------------------
// Flow: a tick request runs through the serial divider
//   (one divider step per cycle over 16 + PHASE_TABLE_BITS quotient bits),
//   one table read and three passes through the shared 8x8 multiplier.
// A new tick is taken only once the last result is in the output register;
//   a held result delays that hand-off and with it the next tick.
// Reset: synchronous active-low rst_n; mode off, colour zero, period 1500 ms,
//   elapsed counter zero, output empty.
`default_nettype none

module led_breathing_color_scaler_unit #(
  parameter int PHASE_TABLE_BITS = lbcs_pkg::PHASE_TABLE_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire [lbcs_pkg::IN_DATA_W-1:0]       in_tdata,   // [0] restart
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [lbcs_pkg::OUT_DATA_W-1:0]     out_tdata,  // [7:0] red_out, [15:8] green_out,
                                                          // [23:16] blue_out
  input  wire                                 cfg_we,
  input  wire [lbcs_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire [lbcs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import lbcs_pkg::*;

  logic [MODE_W-1:0]   mode_r;
  logic [COLOR_W-1:0]  red_r;
  logic [COLOR_W-1:0]  green_r;
  logic [COLOR_W-1:0]  blue_r;
  logic [PERIOD_W-1:0] period_r;
  logic [PERIOD_W-1:0] period_eff;

  dp_cmd_t cmd;
  dp_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_OFF;
      red_r    <= '0;
      green_r  <= '0;
      blue_r   <= '0;
      period_r <= PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MODE:   mode_r   <= cfg_wdata[MODE_W-1:0];
        CFG_RED:    red_r    <= cfg_wdata[COLOR_W-1:0];
        CFG_GREEN:  green_r  <= cfg_wdata[COLOR_W-1:0];
        CFG_BLUE:   blue_r   <= cfg_wdata[COLOR_W-1:0];
        CFG_PERIOD: period_r <= cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // zero period behaves as one
  assign period_eff = (period_r == '0) ? PERIOD_W'(1) : period_r;

  lbcs_ctrl #(
    .PHASE_TABLE_BITS (PHASE_TABLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lbcs_dp #(
    .PHASE_TABLE_BITS (PHASE_TABLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_restart (in_tdata[0]),
    .cmd        (cmd),
    .sts        (sts),
    .mode       (mode_r),
    .base_red   (red_r),
    .base_green (green_r),
    .base_blue  (blue_r),
    .period     (period_eff),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
